FILE: rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

    // Fixed width of the operand and result fields on the ports.
    localparam int FIELD_W = 32;

    // Default internal operand width.
    localparam int MEXP_WIDTH = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } mexp_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power_result;
        logic               zero_modulus;
    } mexp_out_t;

endpackage : mexp_pkg

`default_nettype wire

FILE: rtl/mexp_mulmod.sv
// Bit-serial modular multiplier: MSB-first double-and-add, one modular add per cycle.
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = MEXP_WIDTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic [WIDTH-1:0] m,
    output logic                  done,
    output logic [WIDTH-1:0]      product
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             add_phase_reg, add_phase_next;
    logic             done_reg, done_next;

    logic [WIDTH-1:0] addend;
    logic [WIDTH:0]   sum;
    logic [WIDTH+1:0] diff;
    logic [WIDTH-1:0] sum_mod;

    // The running value and the addend are both below the modulus, so one
    // conditional subtraction brings the sum back into range.
    assign addend  = add_phase_reg ? a_reg : r_reg;
    assign sum     = {1'b0, r_reg} + {1'b0, addend};
    assign diff    = {1'b0, sum} - {2'b00, m_reg};
    assign sum_mod = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];

    always_comb
    begin
        a_next         = a_reg;
        m_next         = m_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        add_phase_next = add_phase_reg;
        done_next      = 1'b0;
        if (start)
        begin
            a_next         = a;
            m_next         = m;
            b_next         = b;
            r_next         = '0;
            cnt_next       = CNT_W'(WIDTH);
            busy_next      = 1'b1;
            add_phase_next = 1'b0;
        end
        else if (busy_reg)
        begin
            r_next = sum_mod;
            if (!add_phase_reg && b_reg[WIDTH-1])
            begin
                add_phase_next = 1'b1;
            end
            else
            begin
                // This bit is finished: move to the next multiplier bit.
                add_phase_next = 1'b0;
                b_next         = {b_reg[WIDTH-2:0], 1'b0};
                cnt_next       = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            add_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            add_phase_reg <= add_phase_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        m_reg <= m_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule : mexp_mulmod

`default_nettype wire

FILE: rtl/modular_exponentiation.sv
// Top level: square-and-multiply sequencer around a shared bit-serial modular multiplier.
//
// Usage: drive operands (base, exponent, modulus) and raise start. The item is
// transferred at a rising edge where start is high and busy is low. busy stays
// high while the item is worked on. The result appears on result, marked by done high
// for a single cycle, and stays there until the next result; the receiver cannot hold it off.
// Operands are unsigned; only the low WIDTH bits of each field are used.
// A zero modulus gives done in the cycle after the transfer. Otherwise the base
// is first reduced with one pass of the multiplier; unless it reduces to zero,
// the exponent is then scanned from bit 0, with one multiplication for every set
// bit and one squaring for every bit below the top set bit. The single shared
// multiplier does one modular add per cycle.
// One item is in flight at a time; done and the drop of busy share a cycle,
// so a new item may be transferred in the cycle that delivers a result.
// Reset abandons any item in progress without producing a result.
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WIDTH = MEXP_WIDTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire mexp_in_t  operands,
    output logic           busy,
    output logic           done,
    output mexp_out_t      result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MRES   = 3'd3;
    localparam logic [2:0] S_MSQ    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] pw_reg, pw_next;
    logic [WIDTH-1:0] res_reg, res_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] mm_a_reg, mm_a_next;
    logic [WIDTH-1:0] mm_b_reg, mm_b_next;
    logic             mm_start_reg, mm_start_next;
    logic             done_reg, done_next;
    mexp_out_t        out_reg, out_next;

    logic [WIDTH-1:0] base_w;
    logic [WIDTH-1:0] exp_w;
    logic [WIDTH-1:0] mod_w;
    logic             mm_done;
    logic [WIDTH-1:0] mm_product;
    logic             accept;

    assign base_w = WIDTH'(operands.base);
    assign exp_w  = WIDTH'(operands.exponent);
    assign mod_w  = WIDTH'(operands.modulus);
    assign accept = start && (state_reg == S_IDLE);

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start_reg),
        .a       (mm_a_reg),
        .b       (mm_b_reg),
        .m       (m_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_comb
    begin
        state_next    = state_reg;
        e_next        = e_reg;
        pw_next       = pw_reg;
        res_next      = res_reg;
        m_next        = m_reg;
        mm_a_next     = mm_a_reg;
        mm_b_next     = mm_b_reg;
        mm_start_next = 1'b0;
        done_next     = 1'b0;
        out_next      = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    m_next = mod_w;
                    e_next = exp_w;
                    if (mod_w == '0)
                    begin
                        out_next  = '{power_result: '0, zero_modulus: 1'b1};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        // Multiplying 1 by the base reduces the base modulo m.
                        mm_a_next     = WIDTH'(1);
                        mm_b_next     = base_w;
                        mm_start_next = 1'b1;
                        state_next    = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    if (mm_product == '0)
                    begin
                        out_next   = '{power_result: '0, zero_modulus: 1'b0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pw_next    = mm_product;
                        res_next   = WIDTH'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (e_reg == '0)
                begin
                    out_next   = '{power_result: FIELD_W'(res_reg), zero_modulus: 1'b0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (e_reg[0])
                begin
                    mm_a_next     = res_reg;
                    mm_b_next     = pw_reg;
                    mm_start_next = 1'b1;
                    state_next    = S_MRES;
                end
                else
                begin
                    mm_a_next     = pw_reg;
                    mm_b_next     = pw_reg;
                    mm_start_next = 1'b1;
                    state_next    = S_MSQ;
                end
            end
            S_MRES:
            begin
                if (mm_done)
                begin
                    res_next = mm_product;
                    // The squaring after the top set bit would never be used.
                    if (e_reg[WIDTH-1:1] == '0)
                    begin
                        out_next   = '{power_result: FIELD_W'(mm_product),
                                       zero_modulus: 1'b0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mm_a_next     = pw_reg;
                        mm_b_next     = pw_reg;
                        mm_start_next = 1'b1;
                        state_next    = S_MSQ;
                    end
                end
            end
            S_MSQ:
            begin
                if (mm_done)
                begin
                    pw_next    = mm_product;
                    e_next     = {1'b0, e_reg[WIDTH-1:1]};
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mm_start_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mm_start_reg <= mm_start_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        pw_reg   <= pw_next;
        res_reg  <= res_next;
        m_reg    <= m_next;
        mm_a_reg <= mm_a_next;
        mm_b_reg <= mm_b_next;
        out_reg  <= out_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = out_reg;

    // A result is only delivered while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result delivered while still busy");

    // A zero modulus is answered in the very next cycle with the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mod_w == '0) |=> (done && result.zero_modulus))
        else $error("zero modulus not flagged on time");

    // Any other item keeps the block busy after the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mod_w != '0) |=> busy)
        else $error("nonzero modulus item did not start");

    // The flag always comes with a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_modulus) |-> (result.power_result == '0))
        else $error("zero modulus with nonzero result");

    // The multiplier only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == S_REDUCE || state_reg == S_MRES || state_reg == S_MSQ))
        else $error("multiplier finished outside a wait state");

endmodule : modular_exponentiation

`default_nettype wire

FILE: bench/mexp_checker.sv
// Checker for the modular exponentiation block: predicts each result and compares it.
`timescale 1ns / 100ps

module mexp_checker
    import mexp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      busy,
    input  wire mexp_in_t  operands,
    input  wire logic      done,
    input  wire mexp_out_t result,
    output int             error_count,
    output int             pending,
    output int             checked
);

    mexp_out_t awaited_powers[$];

    // Right-to-left square-and-multiply over the low MEXP_WIDTH bits of each field.
    function automatic mexp_out_t predict_power(input mexp_in_t op);
        logic [63:0]  op_mask;
        logic [63:0]  b;
        logic [63:0]  e;
        logic [63:0]  m;
        logic [63:0]  acc;
        mexp_out_t    r;
        op_mask = (MEXP_WIDTH >= 64) ? '1 : ((64'd1 << MEXP_WIDTH) - 64'd1);
        b = 64'(op.base) & op_mask;
        e = 64'(op.exponent) & op_mask;
        m = 64'(op.modulus) & op_mask;
        r = '0;
        if (m == 64'd0) begin
            r.zero_modulus = 1'b1;
            return r;
        end
        b = b % m;
        if (b == 64'd0)
            return r;
        acc = 64'd1 % m;
        while (e != 64'd0) begin
            if (e[0])
                acc = 64'((128'(acc) * 128'(b)) % 128'(m));
            e = e >> 1;
            b = 64'((128'(b) * 128'(b)) % 128'(m));
        end
        r.power_result = acc[FIELD_W-1:0];
        return r;
    endfunction

    initial begin
        error_count = 0;
        pending     = 0;
        checked     = 0;
    end

    always @(posedge clk) begin
        mexp_out_t want;
        if (rst_n) begin
            // A result delivered in the same cycle as a new transfer belongs to the older item.
            if (done === 1'b1) begin
                if (awaited_powers.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing awaited: power_result=%h zero_modulus=%b",
                             $time, result.power_result, result.zero_modulus);
                end
                else begin
                    want = awaited_powers.pop_front();
                    checked++;
                    if (result.power_result !== want.power_result) begin
                        error_count++;
                        $display("%0t: power_result mismatch: expected %h, actual %h",
                                 $time, want.power_result, result.power_result);
                    end
                    if (result.zero_modulus !== want.zero_modulus) begin
                        error_count++;
                        $display("%0t: zero_modulus mismatch: expected %b, actual %b",
                                 $time, want.zero_modulus, result.zero_modulus);
                    end
                end
            end
            else if (done !== 1'b0) begin
                error_count++;
                $display("%0t: done is unknown: expected 0 or 1, actual %b", $time, done);
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited_powers.insert(awaited_powers.size(), predict_power(operands));
            pending = awaited_powers.size();
        end
    end

endmodule : mexp_checker

FILE: bench/tb_top.sv
// Testbench top: drives operands into the modular exponentiation block and gives the verdict.
`timescale 1ns / 100ps

module tb_top
    import mexp_pkg::*;
();

    logic      clk;
    logic      rst_n;
    logic      start;
    mexp_in_t  operands;
    logic      busy;
    logic      done;
    mexp_out_t result;

    int error_count;
    int pending;
    int checked;
    int items_sent;
    int directed_items;
    int zero_mod_items;
    int drained_pauses;

    modular_exponentiation u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    mexp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operands    (operands),
        .done        (done),
        .result      (result),
        .error_count (error_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_item(input mexp_in_t op);
        @(negedge clk);
        start    <= 1'b1;
        operands <= op;
        do @(posedge clk); while (busy !== 1'b0);
        items_sent++;
        if (op.modulus == '0)
            zero_mod_items++;
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Hold off the next transfer until every awaited result has come back.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        drained_pauses++;
    endtask

    function automatic mexp_in_t make_operands(input logic [31:0] b, input logic [31:0] e,
                                               input logic [31:0] m);
        mexp_in_t op;
        op.base     = b;
        op.exponent = e;
        op.modulus  = m;
        return op;
    endfunction

    function automatic mexp_in_t random_operands();
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] m;
        int          pick;
        pick = $urandom_range(0, 99);
        b = $urandom();
        e = $urandom();
        m = $urandom();
        if (pick < 5)
            m = '0;
        else if (pick < 12)
            m = $urandom_range(1, 15);
        else if (pick < 18)
        begin
            m = $urandom_range(1, 65535);
            b = m * 32'($urandom_range(0, 65535));
        end
        else if (pick < 23)
            e = '0;
        else if (pick < 60)
            e = e >> $urandom_range(8, 31);
        else if (pick < 65)
            m = m | 32'h8000_0000;
        return make_operands(b, e, m);
    endfunction

    initial begin
        start          = 1'b0;
        operands       = '0;
        rst_n          = 1'b0;
        items_sent     = 0;
        zero_mod_items = 0;
        drained_pauses = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: error case, degenerate moduli and exponents, field extremes.
        send_item(make_operands(32'h1234_5678, 32'h0000_0003, 32'h0000_0000));
        send_item(make_operands(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(make_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_operands(32'hDEAD_BEEF, 32'h0000_0005, 32'h0000_0001));
        send_item(make_operands(32'h0000_0000, 32'h0000_0000, 32'h0000_0007));
        send_item(make_operands(32'h0000_0015, 32'h0000_0000, 32'h0000_0007));
        send_item(make_operands(32'h0000_0015, 32'h0000_0009, 32'h0000_0007));
        send_item(make_operands(32'h0000_0003, 32'h0000_0000, 32'h0000_0007));
        send_item(make_operands(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_operands(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE));
        send_item(make_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_operands(32'h0000_0002, 32'hFFFF_FFFA, 32'hFFFF_FFFB));
        send_item(make_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB));
        send_item(make_operands(32'h0000_0007, 32'h0000_0001, 32'h0000_000D));
        send_item(make_operands(32'h0000_0003, 32'h8000_0000, 32'h8000_0000));
        send_item(make_operands(32'h0000_0003, 32'h8000_0001, 32'h8000_0001));
        send_item(make_operands(32'h1234_5679, 32'hFFFF_FFFF, 32'h0000_0002));
        send_item(make_operands(32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFF));
        send_item(make_operands(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCD));
        send_item(make_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333));
        directed_items = items_sent;
        wait_drained();

        for (int i = 0; i < 250; i++)
        begin
            send_item(random_operands());
            // Items 100 to 169 go back to back with no idling.
            if ((i < 100 || i >= 170) && $urandom_range(0, 99) < 12)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    wait_drained();
                    pause_sender($urandom_range(0, 5));
                end
                else
                    pause_sender($urandom_range(1, 40));
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Sent %0d items (%0d directed, %0d random), %0d with a zero modulus.",
                 items_sent, directed_items, items_sent - directed_items, zero_mod_items);
        $display("Checked %0d results; sender waited for an empty pipeline %0d times.",
                 checked, drained_pauses);
        if (error_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule : tb_top
